### rtl/core/drsr_pkg.sv
// Shared types and constants for the droplet span rasterizer.
// Used by the front end, command queue, span engine, core and checker.
package drsr_pkg;

    localparam int COORD_W   = 12;
    localparam int RAD_W     = 4;
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int STEP_W    = RAD_W + 1;
    localparam int POS_W     = COORD_W + 2;
    localparam int OUT_W     = 11;
    localparam int COLOR_W   = 32;
    localparam int SURF_W    = 12;
    localparam int CFG_IDX_W = 4;

    localparam logic [RAD_W-1:0]  MAX_RADIUS = 4'd15;
    localparam logic [SURF_W-1:0] SURF_LIMIT = 12'd2048;
    localparam logic [SURF_W-1:0] SURF_W_RST = 12'd480;
    localparam logic [SURF_W-1:0] SURF_H_RST = 12'd240;

    localparam logic [CFG_IDX_W-1:0] REG_SURF_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_HEIGHT = 4'd1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [RAD_W-1:0]   rad;
        logic        [RSQ_W-1:0]   rsq;
        logic signed [COORD_W:0]   spike_base;
        logic        [COLOR_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic [SURF_W-1:0] width;
        logic [SURF_W-1:0] height;
    } t_surf;

endpackage

### rtl/core/drsr_front.sv
// Command front end: radius saturation and per-command precompute.
// Depends on drsr_pkg; feeds drsr_queue.
module drsr_front (
    input  logic                                 i_valid,
    input  logic signed [drsr_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [drsr_pkg::COORD_W-1:0]  i_center_y,
    input  logic        [drsr_pkg::RAD_W-1:0]    i_radius,
    input  logic        [drsr_pkg::COLOR_W-1:0]  i_color,
    input  logic                                 i_q_full,
    output logic                                 o_stall,
    output logic                                 o_push,
    output drsr_pkg::t_cmd                       o_cmd
);
    import drsr_pkg::*;

    logic [RAD_W-1:0] rad_sat;

    always_comb begin
        rad_sat          = (i_radius > MAX_RADIUS) ? MAX_RADIUS : i_radius;
        o_cmd.cx         = i_center_x;
        o_cmd.cy         = i_center_y;
        o_cmd.rad        = rad_sat;
        o_cmd.rsq        = RSQ_W'(rad_sat) * RSQ_W'(rad_sat);
        o_cmd.spike_base = $signed({i_center_y[COORD_W-1], i_center_y})
                         - $signed({{(COORD_W-RAD_W){1'b0}}, rad_sat, 1'b0});
        o_cmd.color      = i_color;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

### rtl/core/drsr_queue.sv
// Short command queue between the front end and the span engine.
// Depends on drsr_pkg.
module drsr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  drsr_pkg::t_cmd i_wdata,
    input  logic           i_pop,
    output drsr_pkg::t_cmd o_rdata,
    output logic           o_full,
    output logic           o_empty
);
    import drsr_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= QPTR_W'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= QPTR_W'(r_rp + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

### rtl/core/drsr_back.sv
// Span engine: walks disc and spike rows, integer square root in two steps,
// surface clipping and the output register. Depends on drsr_pkg.
module drsr_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  drsr_pkg::t_surf                    i_surf,
    input  logic                               i_q_empty,
    input  drsr_pkg::t_cmd                     i_cmd,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [drsr_pkg::OUT_W-1:0]         o_span_left,
    output logic [drsr_pkg::OUT_W-1:0]         o_span_right,
    output logic [drsr_pkg::OUT_W-1:0]         o_span_row,
    output logic [drsr_pkg::COLOR_W-1:0]       o_span_color,
    output logic                               o_visible,
    output logic                               o_last_span
);
    import drsr_pkg::*;

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]               r_state;
    t_cmd                     r_cmd;
    logic                     r_disc;
    logic signed [STEP_W-1:0] r_y;
    logic [STEP_W-1:0]        r_j;
    logic [RSQ_W-1:0]         r_v;
    logic [RAD_W-1:0]         r_root;
    logic                     r_step;

    logic                     r_out_vld;
    logic [OUT_W-1:0]         r_left, r_right, r_row;
    logic [COLOR_W-1:0]       r_color;
    logic                     r_vis, r_last;

    logic [RAD_W-1:0]         bit_a, bit_b, cand_a, cand_b, k_a, k_b;
    logic signed [STEP_W-1:0] y_nx, y_abs;
    logic [RSQ_W-1:0]         ysq_nx;
    logic                     disc_end, span_last, out_free;
    logic [RAD_W-1:0]         hw;
    logic signed [POS_W-1:0]  row, left, right, left_c, right_c, wm1, hm1;
    logic [SURF_W-1:0]        w_cl, h_cl;
    logic                     vis;

    // two root bits per cycle
    always_comb begin
        bit_a  = r_step ? 4'd2 : 4'd8;
        bit_b  = r_step ? 4'd1 : 4'd4;
        cand_a = r_root | bit_a;
        k_a    = ((RSQ_W'(cand_a) * RSQ_W'(cand_a)) <= r_v) ? cand_a : r_root;
        cand_b = k_a | bit_b;
        k_b    = ((RSQ_W'(cand_b) * RSQ_W'(cand_b)) <= r_v) ? cand_b : k_a;
    end

    always_comb begin
        y_nx      = r_y + STEP_W'(1);
        y_abs     = y_nx[STEP_W-1] ? -y_nx : y_nx;
        ysq_nx    = RSQ_W'(y_abs[RAD_W-1:0]) * RSQ_W'(y_abs[RAD_W-1:0]);
        disc_end  = (r_y == $signed({1'b0, r_cmd.rad}));
        span_last = r_disc ? (disc_end && r_cmd.rad == '0)
                           : (r_j == STEP_W'({r_cmd.rad, 1'b0} - 1'b1));
        hw        = r_disc ? r_root : r_j[STEP_W-1:1];
        out_free  = !r_out_vld || !i_stall;
    end

    always_comb begin
        w_cl    = (i_surf.width  > SURF_LIMIT) ? SURF_LIMIT : i_surf.width;
        h_cl    = (i_surf.height > SURF_LIMIT) ? SURF_LIMIT : i_surf.height;
        wm1     = $signed({2'b00, w_cl}) - POS_W'(1);
        hm1     = $signed({2'b00, h_cl}) - POS_W'(1);
        row     = r_disc
                ? $signed({{2{r_cmd.cy[COORD_W-1]}}, r_cmd.cy})
                  + $signed({{(POS_W-STEP_W){r_y[STEP_W-1]}}, r_y})
                : $signed({r_cmd.spike_base[COORD_W], r_cmd.spike_base})
                  + $signed({{(POS_W-STEP_W){1'b0}}, r_j});
        left    = $signed({{2{r_cmd.cx[COORD_W-1]}}, r_cmd.cx})
                - $signed({{(POS_W-RAD_W){1'b0}}, hw});
        right   = $signed({{2{r_cmd.cx[COORD_W-1]}}, r_cmd.cx})
                + $signed({{(POS_W-RAD_W){1'b0}}, hw});
        left_c  = left[POS_W-1] ? '0 : left;
        right_c = (right > wm1) ? wm1 : right;
        vis     = (left_c <= right_c) && !row[POS_W-1] && (row <= hm1);
    end

    assign o_pop = (r_state == S_LOAD) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (!i_q_empty) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_step) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (span_last) begin
                            r_state <= S_LOAD;
                        end else if (r_disc && !disc_end) begin
                            r_state <= S_ROOT;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_cmd  <= i_cmd;
                r_disc <= 1'b1;
                r_y    <= -$signed({1'b0, i_cmd.rad});
                r_j    <= '0;
                r_v    <= '0;
                r_root <= '0;
                r_step <= 1'b0;
            end
            S_ROOT: begin
                r_root <= k_b;
                r_step <= !r_step;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_left  <= vis ? left_c[OUT_W-1:0]  : '0;
                    r_right <= vis ? right_c[OUT_W-1:0] : '0;
                    r_row   <= vis ? row[OUT_W-1:0]     : '0;
                    r_color <= r_cmd.color;
                    r_vis   <= vis;
                    r_last  <= span_last;
                    if (r_disc) begin
                        if (disc_end) begin
                            r_disc <= 1'b0;
                            r_j    <= '0;
                        end else begin
                            r_y    <= y_nx;
                            r_v    <= r_cmd.rsq - ysq_nx;
                            r_root <= '0;
                            r_step <= 1'b0;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid      = r_out_vld;
    assign o_span_left  = r_left;
    assign o_span_right = r_right;
    assign o_span_row   = r_row;
    assign o_span_color = r_color;
    assign o_visible    = r_vis;
    assign o_last_span  = r_last;

endmodule

### rtl/core/droplet_span_rasterizer_core.sv
// Droplet span rasterizer top level: configuration registers, front end,
// command queue and span engine. Depends on drsr_pkg, drsr_front,
// drsr_queue and drsr_back.
//
// Usage: a droplet command (center, radius, color) enters on i_valid while
// o_stall is low. It yields 4r+1 spans (r saturated to 15): disc rows top
// to bottom, then spike rows, each clipped to the surface. Spans leave on
// o_valid while i_stall is low; o_last_span marks the final span.
// Surface size is written on the cfg channel (o_cfg_ready is always high);
// index 0 is width, 1 is height, other indexes are ignored.
// An accepted command passes through the queue, the load state, two
// square-root steps and the emit state before its first span reaches the
// output register. Each disc span repeats the square-root steps before
// its emit, spike spans go out from S_EMIT alone, and each command loads.
// A two-deep command queue lets up to two commands wait while the engine
// works; o_stall rises when it is full. When i_stall is high the held
// span stays on the outputs and the engine waits at its next emit.
// Reset clears the queue and output valid and restores the surface to
// 480 x 240.
module droplet_span_rasterizer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [drsr_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [drsr_pkg::COORD_W-1:0]  i_center_y,
    input  logic        [drsr_pkg::RAD_W-1:0]    i_radius,
    input  logic        [drsr_pkg::COLOR_W-1:0]  i_color,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [drsr_pkg::OUT_W-1:0]    o_span_left,
    output logic        [drsr_pkg::OUT_W-1:0]    o_span_right,
    output logic        [drsr_pkg::OUT_W-1:0]    o_span_row,
    output logic        [drsr_pkg::COLOR_W-1:0]  o_span_color,
    output logic                                 o_visible,
    output logic                                 o_last_span,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [drsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [drsr_pkg::SURF_W-1:0]   i_cfg_data
);
    import drsr_pkg::*;

    t_surf r_surf;
    t_cmd  push_cmd, pop_cmd;
    logic  push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf.width  <= SURF_W_RST;
            r_surf.height <= SURF_H_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SURF_WIDTH:  r_surf.width  <= i_cfg_data;
                REG_SURF_HEIGHT: r_surf.height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    drsr_front u_front (
        .i_valid    (i_valid),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .i_q_full   (q_full),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    drsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (pop_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    drsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_surf       (r_surf),
        .i_q_empty    (q_empty),
        .i_cmd        (pop_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_span_left  (o_span_left),
        .o_span_right (o_span_right),
        .o_span_row   (o_span_row),
        .o_span_color (o_span_color),
        .o_visible    (o_visible),
        .o_last_span  (o_last_span)
    );

endmodule

### rtl/core/drsr_checker.sv
// Port-level checks for droplet_span_rasterizer_core, bound to the top.
// Depends on drsr_pkg.
module drsr_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_stall,
    input  logic                                 o_valid,
    input  logic        [drsr_pkg::OUT_W-1:0]    o_span_left,
    input  logic        [drsr_pkg::OUT_W-1:0]    o_span_right,
    input  logic        [drsr_pkg::OUT_W-1:0]    o_span_row,
    input  logic        [drsr_pkg::COLOR_W-1:0]  o_span_color,
    input  logic                                 o_visible,
    input  logic                                 o_last_span
);
    import drsr_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_span_left)
            && $stable(o_span_right) && $stable(o_span_row)
            && $stable(o_span_color) && $stable(o_visible)
            && $stable(o_last_span))
        else $error("stalled span changed");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_span_left == '0 && o_span_right == '0
            && o_span_row == '0)
        else $error("hidden span has coordinates");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> o_span_left <= o_span_right)
        else $error("visible span reversed");

endmodule

bind droplet_span_rasterizer_core drsr_checker u_drsr_checker (.*);

### tb/sv/droplet_span_rasterizer_core_checker.sv
// Span checker for droplet_span_rasterizer_core: tracks surface writes, predicts
// the spans of each accepted droplet request and compares the emitted spans.
// Depends on drsr_pkg.
module droplet_span_rasterizer_core_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    input  logic                                  i_req_stall,
    input  logic signed [drsr_pkg::COORD_W-1:0]   i_center_x,
    input  logic signed [drsr_pkg::COORD_W-1:0]   i_center_y,
    input  logic        [drsr_pkg::RAD_W-1:0]     i_radius,
    input  logic        [drsr_pkg::COLOR_W-1:0]   i_color,
    input  logic                                  i_span_valid,
    input  logic                                  i_span_stall,
    input  logic        [drsr_pkg::OUT_W-1:0]     i_span_left,
    input  logic        [drsr_pkg::OUT_W-1:0]     i_span_right,
    input  logic        [drsr_pkg::OUT_W-1:0]     i_span_row,
    input  logic        [drsr_pkg::COLOR_W-1:0]   i_span_color,
    input  logic                                  i_visible,
    input  logic                                  i_last_span,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic        [drsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [drsr_pkg::SURF_W-1:0]    i_cfg_data,
    output int                                    o_err_count,
    output int                                    o_pending,
    output int                                    o_span_count,
    output int                                    o_visible_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import drsr_pkg::*;

    localparam int SURFACE_CAP = 2048;

    typedef struct {
        logic [OUT_W-1:0]   left;
        logic [OUT_W-1:0]   right;
        logic [OUT_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic               vis;
        logic               last;
    } t_span;

    t_span             pending_spans[$];
    logic [SURF_W-1:0] surface_w;
    logic [SURF_W-1:0] surface_h;
    int                errors = 0;
    int                spans_seen = 0;
    int                spans_visible = 0;

    function automatic int int_sqrt(int v);
        int k;
        k = 0;
        while ((k + 1) * (k + 1) <= v)
            k++;
        return k;
    endfunction

    function automatic t_span clip_span(int cx, int row, int hw, logic [COLOR_W-1:0] col,
                                        bit last);
        t_span s;
        int    w;
        int    h;
        int    l;
        int    r;
        bit    vis;
        w = (surface_w > SURFACE_CAP) ? SURFACE_CAP : int'(surface_w);
        h = (surface_h > SURFACE_CAP) ? SURFACE_CAP : int'(surface_h);
        l = cx - hw;
        r = cx + hw;
        if (l < 0)
            l = 0;
        if (r > w - 1)
            r = w - 1;
        vis     = (l <= r) && (row >= 0) && (row <= h - 1);
        s.left  = vis ? OUT_W'(l) : '0;
        s.right = vis ? OUT_W'(r) : '0;
        s.row   = vis ? OUT_W'(row) : '0;
        s.color = col;
        s.vis   = vis;
        s.last  = last;
        return s;
    endfunction

    // disc rows top to bottom, then spike rows from cy - 2 * rad down to cy - 1
    task automatic plan_droplet_spans(int cx, int cy, int rad, logic [COLOR_W-1:0] col);
        int total;
        int n;
        total = 4 * rad + 1;
        n = 0;
        for (int y = -rad; y <= rad; y++) begin
            n++;
            pending_spans.push_back(clip_span(cx, cy + y, int_sqrt(rad * rad - y * y), col,
                                              n == total));
        end
        for (int y = 0; y < 2 * rad; y++) begin
            n++;
            pending_spans.push_back(clip_span(cx, cy - 2 * rad + y, y / 2, col, n == total));
        end
    endtask

    task automatic check_field(string name, longint exp, longint act);
        if (exp != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            surface_w = SURF_W_RST;
            surface_h = SURF_H_RST;
            pending_spans.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SURF_WIDTH: begin
                        surface_w = i_cfg_data;
                    end
                    REG_SURF_HEIGHT: begin
                        surface_h = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                plan_droplet_spans(i_center_x, i_center_y,
                                   (i_radius > MAX_RADIUS) ? MAX_RADIUS : i_radius, i_color);
            end
            if (i_span_valid && !i_span_stall) begin
                spans_seen++;
                if (i_visible)
                    spans_visible++;
                if (pending_spans.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected span, expected none, actual row %0d cols %0d..%0d",
                             $time, i_span_row, i_span_left, i_span_right);
                end else begin
                    t_span s;
                    s = pending_spans.pop_front();
                    check_field("span_left", s.left, i_span_left);
                    check_field("span_right", s.right, i_span_right);
                    check_field("span_row", s.row, i_span_row);
                    check_field("span_color", s.color, i_span_color);
                    check_field("visible", s.vis, i_visible);
                    check_field("last_span", s.last, i_last_span);
                end
            end
        end
        o_err_count     <= errors;
        o_pending       <= pending_spans.size();
        o_span_count    <= spans_seen;
        o_visible_count <= spans_visible;
    end

endmodule

### tb/sv/droplet_span_rasterizer_core_tb.sv
// Testbench top for droplet_span_rasterizer_core: clock, reset, droplet
// requests, surface writes and output stalls; checking is in the checker.
// Depends on drsr_pkg, droplet_span_rasterizer_core and its checker.
module droplet_span_rasterizer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import drsr_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASES        = 10;
    localparam int RANDOM_PER_PH = 36;
    localparam int PRESSURE_REQS = 30;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [RAD_W-1:0]   rad;
        logic        [COLOR_W-1:0] color;
    } t_droplet;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic        [RAD_W-1:0]   i_radius = '0;
    logic        [COLOR_W-1:0] i_color = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic        [OUT_W-1:0]   o_span_left;
    logic        [OUT_W-1:0]   o_span_right;
    logic        [OUT_W-1:0]   o_span_row;
    logic        [COLOR_W-1:0] o_span_color;
    logic                      o_visible;
    logic                      o_last_span;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic        [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic        [SURF_W-1:0]  i_cfg_data = '0;

    int          err_count;
    int          pending;
    int          span_count;
    int          visible_count;
    int unsigned cycle_count = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_pct = 0;
    int          stall_phase_left = 0;
    int          requests_sent = 0;
    int          surfaces_used = 1;
    int          surf_w = 480;
    int          surf_h = 240;
    t_droplet    droplet_q[$];

    droplet_span_rasterizer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_color      (i_color),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_span_left  (o_span_left),
        .o_span_right (o_span_right),
        .o_span_row   (o_span_row),
        .o_span_color (o_span_color),
        .o_visible    (o_visible),
        .o_last_span  (o_last_span),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    droplet_span_rasterizer_core_checker span_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius        (i_radius),
        .i_color         (i_color),
        .i_span_valid    (o_valid),
        .i_span_stall    (i_stall),
        .i_span_left     (o_span_left),
        .i_span_right    (o_span_right),
        .i_span_row      (o_span_row),
        .i_span_color    (o_span_color),
        .i_visible       (o_visible),
        .i_last_span     (o_last_span),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_err_count     (err_count),
        .o_pending       (pending),
        .o_span_count    (span_count),
        .o_visible_count (visible_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d spans still expected", $time, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output side: long hold-off on request, else random stall density per stretch
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            if (stall_phase_left == 0) begin
                stall_phase_left <= $urandom_range(16, 200);
                case ($urandom_range(4))
                    0, 1: stall_pct <= 0;
                    2: stall_pct <= 20;
                    3: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end else begin
                stall_phase_left <= stall_phase_left - 1;
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_droplet make_droplet(int cx, int cy, int rad, logic [COLOR_W-1:0] col);
        t_droplet d;
        d.cx    = COORD_W'(cx);
        d.cy    = COORD_W'(cy);
        d.rad   = RAD_W'(rad);
        d.color = col;
        return d;
    endfunction

    // mostly droplets around the surface, some anywhere in the coordinate range
    function automatic t_droplet random_droplet();
        int pick;
        int w;
        int h;
        int rad;
        w = (surf_w > 2048) ? 2048 : surf_w;
        h = (surf_h > 2048) ? 2048 : surf_h;
        pick = $urandom_range(99);
        rad = (pick < 15) ? int'(MAX_RADIUS) : (pick < 25) ? 0 : $urandom_range(15);
        if ($urandom_range(3) != 0)
            return make_droplet($urandom_range(w + 40) - 20, $urandom_range(h + 40) - 20,
                                rad, $urandom);
        return make_droplet($urandom_range(4095), $urandom_range(4095), rad, $urandom);
    endfunction

    task automatic send_request(t_droplet d);
        i_valid    <= 1'b1;
        i_center_x <= d.cx;
        i_center_y <= d.cy;
        i_radius   <= d.rad;
        i_color    <= d.color;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    task automatic issue_requests();
        int burst;
        int gap;
        burst = 0;
        while (droplet_q.size() != 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            send_request(droplet_q.pop_front());
            burst--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SURF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // width, height, then a write to an unused index that must change nothing
    task automatic write_surface(int w, int h);
        cfg_write(REG_SURF_WIDTH, SURF_W'(w));
        cfg_write(REG_SURF_HEIGHT, SURF_W'(h));
        cfg_write(CFG_IDX_W'($urandom_range(2, 15)), SURF_W'($urandom));
        i_cfg_valid <= 1'b0;
        surf_w = w;
        surf_h = h;
        surfaces_used++;
    endtask

    task automatic queue_corner_droplets();
        int w;
        int h;
        w = (surf_w > 2048) ? 2048 : surf_w;
        h = (surf_h > 2048) ? 2048 : surf_h;
        droplet_q.push_back(make_droplet(0, 0, MAX_RADIUS, $urandom));
        droplet_q.push_back(make_droplet(w - 1, h - 1, MAX_RADIUS, $urandom));
        droplet_q.push_back(make_droplet(2047, 2047, MAX_RADIUS, $urandom));
        droplet_q.push_back(make_droplet(-2048, -2048, 0, $urandom));
    endtask

    initial begin
        int phase_w[PHASES] = '{1, 2048, 4095, 0, 0, 480, 64, 640, 0, 0};
        int phase_h[PHASES] = '{1, 2048, 4095, 0, 240, 0, 32, 480, 0, 0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed set on the reset surface, 480 x 240
        droplet_q.push_back(make_droplet(10, 10, 0, 32'h0000_0000));
        droplet_q.push_back(make_droplet(240, 120, 15, 32'hFFFF_FFFF));
        droplet_q.push_back(make_droplet(0, 0, 15, 32'hA5A5_A5A5));
        droplet_q.push_back(make_droplet(479, 239, 15, 32'h5A5A_5A5A));
        droplet_q.push_back(make_droplet(-2048, -2048, 15, 32'h8000_0000));
        droplet_q.push_back(make_droplet(2047, 2047, 15, 32'h7FFF_FFFF));
        droplet_q.push_back(make_droplet(-1, 100, 0, 32'h0000_0001));
        droplet_q.push_back(make_droplet(480, 100, 0, 32'h0000_0002));
        droplet_q.push_back(make_droplet(100, -1, 0, 32'h0000_0003));
        droplet_q.push_back(make_droplet(100, 240, 0, 32'h0000_0004));
        droplet_q.push_back(make_droplet(-15, 100, 15, 32'h1234_5678));
        droplet_q.push_back(make_droplet(494, 100, 15, 32'h8765_4321));
        droplet_q.push_back(make_droplet(100, 30, 15, 32'hCAFE_0001));
        droplet_q.push_back(make_droplet(100, 29, 15, 32'hCAFE_0002));
        droplet_q.push_back(make_droplet(100, 224, 15, 32'hCAFE_0003));
        droplet_q.push_back(make_droplet(100, 225, 15, 32'hCAFE_0004));
        droplet_q.push_back(make_droplet(200, 100, 1, 32'h0F0F_0F0F));
        droplet_q.push_back(make_droplet(200, 100, 2, 32'hF0F0_F0F0));
        droplet_q.push_back(make_droplet(200, 100, 7, 32'h3333_3333));
        droplet_q.push_back(make_droplet(200, 100, 8, 32'hCCCC_CCCC));
        issue_requests();
        wait_drained();

        // output held off while requests keep coming, so the input stalls
        hold_seq <= hold_seq + 1;
        repeat (PRESSURE_REQS) droplet_q.push_back(random_droplet());
        issue_requests();
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p >= PHASES - 2)
                write_surface($urandom_range(1, 4095), $urandom_range(1, 4095));
            else
                write_surface(phase_w[p], phase_h[p]);
            queue_corner_droplets();
            repeat (RANDOM_PER_PH) droplet_q.push_back(random_droplet());
            issue_requests();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d droplet requests over %0d surface settings", requests_sent,
                 surfaces_used);
        $display("Checked %0d spans, %0d of them visible", span_count, visible_count);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
